// ===== design/bea_pkg.sv =====
package bea_pkg;

  localparam int MapW   = 28;
  localparam int TimeW  = 32;
  localparam int DelayW = 24;
  localparam int ActW   = 4;
  localparam int PhaseW = 2;
  localparam int CfgIdxW = 1;

  typedef logic [MapW-1:0]   map_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [DelayW-1:0] delay_t;
  typedef logic [ActW-1:0]   act_t;
  typedef logic [PhaseW-1:0] phase_t;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_START_DELAY    = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_CONTINUE_DELAY = 1'd1;

  localparam delay_t START_DELAY_RST    = 24'd500000;
  localparam delay_t CONTINUE_DELAY_RST = 24'd100000;

  // actions
  localparam act_t ACT_NONE      = 4'd0;
  localparam act_t ACT_BACK      = 4'd1;
  localparam act_t ACT_EXIT      = 4'd2;
  localparam act_t ACT_SELECT    = 4'd3;
  localparam act_t ACT_UP        = 4'd4;
  localparam act_t ACT_DOWN      = 4'd5;
  localparam act_t ACT_LEFT      = 4'd6;
  localparam act_t ACT_RIGHT     = 4'd7;
  localparam act_t ACT_PAGE_UP   = 4'd8;
  localparam act_t ACT_PAGE_DOWN = 4'd9;

  // repeat phases
  localparam phase_t PH_IDLE   = 2'd0;
  localparam phase_t PH_FIRST  = 2'd1;
  localparam phase_t PH_REPEAT = 2'd2;

  // button bit positions
  localparam int BTN_UP    = 0;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_DOWN  = 4;
  localparam int BTN_RIGHT = 6;
  localparam int BTN_L     = 10;
  localparam int BTN_R     = 11;
  localparam int BTN_A     = 12;
  localparam int BTN_B     = 13;
  localparam int BTN_X     = 14;

  localparam logic MODE_POLL  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // highest priority last in the chain wins
  function automatic act_t pick_action(input map_t fresh);
    act_t act;
    act = ACT_NONE;
    if (fresh[BTN_A])     act = ACT_BACK;
    if (fresh[BTN_X])     act = ACT_EXIT;
    if (fresh[BTN_B])     act = ACT_SELECT;
    if (fresh[BTN_UP])    act = ACT_UP;
    if (fresh[BTN_DOWN])  act = ACT_DOWN;
    if (fresh[BTN_LEFT])  act = ACT_LEFT;
    if (fresh[BTN_RIGHT]) act = ACT_RIGHT;
    if (fresh[BTN_L])     act = ACT_PAGE_UP;
    if (fresh[BTN_R])     act = ACT_PAGE_DOWN;
    return act;
  endfunction

endpackage

// ===== design/button_edge_autorepeat.sv =====
// Path from input transaction to out_valid: input register, then result register.
// Throughput: one transaction per cycle; the only stall is a held result when out_ready is low.
// State update (edge history, repeat timer) happens in the result stage, one item per cycle unless a result is held.
// Reset: synchronous, active low; clears pipeline valids, edge history and repeat state,
// and loads the default start/continue delays.
module button_edge_autorepeat import bea_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  map_t               in_pressed_map,
  input  time_t              in_now_us,
  output logic               out_valid,
  input  logic               out_ready,
  output act_t               out_action,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  delay_t             cfg_data
);

  logic   s1_valid_r;
  logic   s1_mode_r;
  map_t   s1_map_r;
  time_t  s1_now_r;

  logic   out_valid_r;
  act_t   out_action_r;

  delay_t start_delay_r;
  delay_t continue_delay_r;

  map_t   prev_map_r,  prev_map_nxt;
  phase_t phase_r,     phase_nxt;
  map_t   rpt_mask_r,  rpt_mask_nxt;
  act_t   rpt_action_r, rpt_action_nxt;
  time_t  rpt_stamp_r, rpt_stamp_nxt;
  act_t   act_nxt;

  map_t   fresh;
  act_t   new_act;
  time_t  elapsed;
  logic   over_start;
  logic   over_cont;
  logic   advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign fresh   = s1_map_r & ~prev_map_r;
  assign new_act = pick_action(fresh);
  assign elapsed = s1_now_r - rpt_stamp_r;
  // elapsed > delay, with the delay zero-extended to 32 bits
  assign over_start = (elapsed[TimeW-1:DelayW] != '0) || (elapsed[DelayW-1:0] > start_delay_r);
  assign over_cont  = (elapsed[TimeW-1:DelayW] != '0) ||
                      (elapsed[DelayW-1:0] > continue_delay_r);

  always_comb begin
    prev_map_nxt   = prev_map_r;
    phase_nxt      = phase_r;
    rpt_mask_nxt   = rpt_mask_r;
    rpt_action_nxt = rpt_action_r;
    rpt_stamp_nxt  = rpt_stamp_r;
    act_nxt        = ACT_NONE;
    if (s1_mode_r == MODE_CLEAR) begin
      prev_map_nxt = '0;
      phase_nxt    = PH_IDLE;
    end else begin
      prev_map_nxt = s1_map_r;
      if (new_act != ACT_NONE) begin
        act_nxt        = new_act;
        rpt_stamp_nxt  = s1_now_r;
        phase_nxt      = PH_FIRST;
        rpt_mask_nxt   = fresh;
        rpt_action_nxt = new_act;
      end else if ((s1_map_r & rpt_mask_r) != '0) begin
        case (phase_r)
          PH_FIRST: begin
            if (over_start) begin
              act_nxt       = rpt_action_r;
              rpt_stamp_nxt = s1_now_r;
              phase_nxt     = PH_REPEAT;
            end
          end
          PH_REPEAT: begin
            if (over_cont) begin
              act_nxt       = rpt_action_r;
              rpt_stamp_nxt = s1_now_r;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      start_delay_r    <= START_DELAY_RST;
      continue_delay_r <= CONTINUE_DELAY_RST;
      prev_map_r       <= '0;
      phase_r          <= PH_IDLE;
      rpt_mask_r       <= '0;
      rpt_action_r     <= ACT_NONE;
      rpt_stamp_r      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        prev_map_r   <= prev_map_nxt;
        phase_r      <= phase_nxt;
        rpt_mask_r   <= rpt_mask_nxt;
        rpt_action_r <= rpt_action_nxt;
        rpt_stamp_r  <= rpt_stamp_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_DELAY:    start_delay_r    <= cfg_data;
          REG_CONTINUE_DELAY: continue_delay_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r <= in_mode;
      s1_map_r  <= in_pressed_map;
      s1_now_r  <= in_now_us;
    end
    if (advance) begin
      out_action_r <= act_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;

endmodule

// ===== design/bea_checker.sv =====
module bea_checker import bea_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input act_t               out_action,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action))
    else $error("result changed or dropped while stalled");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_action <= ACT_PAGE_DOWN)
    else $error("action code out of range");

  // input side only backs up when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result register");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst_n) == 1'b0 && rst_n |-> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write not taken");

endmodule

bind button_edge_autorepeat bea_checker u_bea_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_action (out_action),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// ===== dv/button_edge_autorepeat_tb.sv =====
`timescale 1ns / 100ps

module button_edge_autorepeat_tb;
  import bea_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 100;
  localparam int MAX_PRINTED  = 50;

  // Mirror of the key repeat logic plus the queue of actions still owed by the block.
  class autorepeat_sb;
    delay_t start_dly;
    delay_t cont_dly;
    map_t   prev_map;
    map_t   rep_mask;
    phase_t phase;
    act_t   rep_act;
    time_t  stamp;
    act_t   act_q[$];
    int     n_checked;
    int     n_err;

    function new();
      start_dly = START_DELAY_RST;
      cont_dly  = CONTINUE_DELAY_RST;
      prev_map  = '0;
      rep_mask  = '0;
      phase     = PH_IDLE;
      rep_act   = ACT_NONE;
      stamp     = '0;
      n_checked = 0;
      n_err     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, delay_t val);
      case (idx)
        REG_START_DELAY:    start_dly = val;
        REG_CONTINUE_DELAY: cont_dly  = val;
        default: ;
      endcase
    endfunction

    // strongest button first
    function act_t press_action(map_t fresh);
      if (fresh[BTN_R])     return ACT_PAGE_DOWN;
      if (fresh[BTN_L])     return ACT_PAGE_UP;
      if (fresh[BTN_RIGHT]) return ACT_RIGHT;
      if (fresh[BTN_LEFT])  return ACT_LEFT;
      if (fresh[BTN_DOWN])  return ACT_DOWN;
      if (fresh[BTN_UP])    return ACT_UP;
      if (fresh[BTN_B])     return ACT_SELECT;
      if (fresh[BTN_X])     return ACT_EXIT;
      if (fresh[BTN_A])     return ACT_BACK;
      return ACT_NONE;
    endfunction

    function void note_item(logic mode, map_t map, time_t now);
      map_t  fresh;
      act_t  act;
      time_t elapsed;
      act = ACT_NONE;
      if (mode == MODE_CLEAR) begin
        // mask, action and stamp survive a clear
        prev_map = '0;
        phase    = PH_IDLE;
      end else begin
        fresh    = map & ~prev_map;
        prev_map = map;
        act      = press_action(fresh);
        if (act != ACT_NONE) begin
          stamp    = now;
          phase    = PH_FIRST;
          rep_mask = fresh;
          rep_act  = act;
        end else if ((map & rep_mask) != '0) begin
          elapsed = now - stamp;
          if (phase == PH_FIRST && elapsed > time_t'(start_dly)) begin
            act   = rep_act;
            stamp = now;
            phase = PH_REPEAT;
          end else if (phase == PH_REPEAT && elapsed > time_t'(cont_dly)) begin
            act   = rep_act;
            stamp = now;
          end
        end
      end
      act_q.push_back(act);
    endfunction

    task check_action(act_t got);
      act_t want;
      n_checked++;
      if (act_q.size() == 0) begin
        report($sformatf("result transaction with nothing pending, action=%0d", got));
        return;
      end
      want = act_q.pop_front();
      if (got !== want)
        report($sformatf("result #%0d action=%0d, want %0d", n_checked, got, want));
    endtask

    task report(string msg);
      if (n_err < MAX_PRINTED)
        $display("[%0t] MISMATCH: %s", $time, msg);
      n_err++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = MODE_POLL;
  map_t               in_pressed_map = '0;
  time_t              in_now_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  act_t               out_action;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_START_DELAY;
  delay_t             cfg_data = '0;

  autorepeat_sb sb;
  int           n_sent = 0;
  int unsigned  n_cycles = 0;
  map_t         held = '0;
  time_t        t_now = '0;
  bit           steady = 1'b0;
  bit           hold_req = 1'b0;
  bit           hold_done = 1'b0;

  button_edge_autorepeat u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_pressed_map (in_pressed_map),
    .in_now_us      (in_now_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("button_edge_autorepeat_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_action(out_action);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 20);
    return $urandom_range(50, 150);
  endfunction

  function automatic map_t press_bits();
    int   btns[9] = '{BTN_UP, BTN_LEFT, BTN_DOWN, BTN_RIGHT, BTN_L, BTN_R, BTN_A, BTN_B, BTN_X};
    map_t m;
    m = '0;
    m[btns[$urandom_range(0, 8)]] = 1'b1;
    if ($urandom_range(0, 2) == 0) m[btns[$urandom_range(0, 8)]] = 1'b1;
    if ($urandom_range(0, 9) == 0) m[$urandom_range(0, MapW - 1)] = 1'b1;
    return m;
  endfunction

  // steer time around the delay that is armed right now, so both sides of the
  // strict compare get hit
  function automatic time_t next_time();
    time_t d;
    int    r;
    d = (sb.phase == PH_REPEAT) ? time_t'(sb.cont_dly) : time_t'(sb.start_dly);
    r = $urandom_range(0, 99);
    if (r < 35) return t_now + $urandom_range(0, d / 8 + 2);
    if (r < 65) return sb.stamp + d - 1 + $urandom_range(0, 3);
    if (r < 90) return t_now + $urandom_range(0, 2 * d + 2);
    return $urandom;
  endfunction

  task automatic send_item(logic mode, map_t map, time_t now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_pressed_map <= map;
    in_now_us      <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(mode, map, now);
    n_sent++;
  endtask

  task automatic write_delays(delay_t start_val, delay_t cont_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_DELAY;
    cfg_data  <= start_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(REG_START_DELAY, start_val);
    cfg_index <= REG_CONTINUE_DELAY;
    cfg_data  <= cont_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(REG_CONTINUE_DELAY, cont_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.n_checked < n_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    int    btns[9] = '{BTN_A, BTN_X, BTN_B, BTN_UP, BTN_DOWN, BTN_LEFT, BTN_RIGHT, BTN_L, BTN_R};
    map_t  m;
    time_t t0;
    m  = '0;
    t0 = 32'hFFFF_FF00;
    send_item(MODE_POLL, '0, t0);
    // add buttons weakest first so each new press wins
    foreach (btns[k]) begin
      m[btns[k]] = 1'b1;
      send_item(MODE_POLL, m, t0 + k);
    end
    send_item(MODE_POLL, '0, t0 + 50);
    send_item(MODE_POLL, m, t0 + 100);
    // exactly at the start delay (no repeat), then one past it; time wraps here
    send_item(MODE_POLL, m, t0 + 100 + START_DELAY_RST);
    // extra unmapped press has no action of its own, repeat still runs
    send_item(MODE_POLL, m | map_t'(2), t0 + 101 + START_DELAY_RST);
    send_item(MODE_POLL, m | map_t'(2), t0 + 101 + START_DELAY_RST + CONTINUE_DELAY_RST);
    send_item(MODE_POLL, m | map_t'(2), t0 + 102 + START_DELAY_RST + CONTINUE_DELAY_RST);
    send_item(MODE_CLEAR, '1, '1);
    send_item(MODE_POLL, m, t0 + 200);
    send_item(MODE_POLL, '1, '1);
    send_item(MODE_POLL, '0, '0);
    send_item(MODE_CLEAR, '0, '0);
    t_now = '0;
    held  = '0;
  endtask

  task automatic run_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(MODE_CLEAR, map_t'($urandom), $urandom);
      end else if (r < 10) begin
        held  = map_t'($urandom);
        t_now = $urandom;
        send_item(MODE_POLL, held, t_now);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30)
          held |= press_bits();
        else if (r < 45)
          held &= map_t'($urandom);
        t_now = next_time();
        send_item(MODE_POLL, held, t_now);
      end
    end
  endtask

  // result side: random ready, plus one long hold-off once asked for
  initial begin : result_sink
    int run_len;
    int stall_len;
    forever begin
      run_len = pick_run();
      out_ready <= 1'b1;
      repeat (run_len) begin
        @(posedge clk);
        if (hold_req && !hold_done) break;
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_ready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset delays first
    run_directed();
    run_random(RANDOM_ITEMS);
    drain();

    for (int ph = 1; ph < 6; ph++) begin
      case (ph)
        1: write_delays('0, '0);
        2: write_delays('1, '1);
        3: write_delays(delay_t'($urandom_range(1, 300)), delay_t'($urandom_range(1, 100)));
        4: write_delays(delay_t'($urandom), delay_t'($urandom));
        default: write_delays('0, '1);
      endcase
      steady = (ph == 1);
      if (ph == 3) hold_req <= 1'b1;
      run_random(RANDOM_ITEMS);
      drain();
    end

    if (sb.act_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.act_q.size()));
    if (sb.n_err == 0)
      $display("button_edge_autorepeat_tb: PASS");
    else
      $display("button_edge_autorepeat_tb: FAIL");
    $finish;
  end

endmodule
